@@ hdl/duration_string_to_seconds_core_macros.svh @@
// Assertion macros used by the duration parser top level.
`ifndef DURATION_STRING_TO_SECONDS_CORE_MACROS_SVH
`define DURATION_STRING_TO_SECONDS_CORE_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define DSTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define DSTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dsts_pkg.sv @@
// Types, constants and helper functions of the duration parser.
package dsts_pkg;

  localparam int unsigned CntW  = 31;
  localparam int unsigned ScaleW = 17;

  localparam logic [CntW-1:0] Max31 = 31'h7FFF_FFFF;

  // Parser phase within one duration string.
  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_EXPECT   = 3'd1,
    PH_NUMBER   = 3'd2,
    PH_AFTER_M  = 3'd3,
    PH_AFTER_MI = 3'd4,
    PH_AFTER_S  = 3'd5,
    PH_AFTER_SE = 3'd6
  } phase_e;

  // Unit ranks; a new unit must rank strictly below the previous one.
  localparam logic [2:0] RankSec  = 3'd0;
  localparam logic [2:0] RankMin  = 3'd1;
  localparam logic [2:0] RankHour = 3'd2;
  localparam logic [2:0] RankDay  = 3'd3;
  localparam logic [2:0] RankNone = 3'd4;

  // Characters the parser recognizes.
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChD    = 8'h64;
  localparam logic [7:0] ChH    = 8'h68;
  localparam logic [7:0] ChM    = 8'h6D;
  localparam logic [7:0] ChS    = 8'h73;
  localparam logic [7:0] ChI    = 8'h69;
  localparam logic [7:0] ChN    = 8'h6E;
  localparam logic [7:0] ChE    = 8'h65;
  localparam logic [7:0] ChC    = 8'h63;

  // Parser state carried from one character to the next.
  typedef struct packed {
    phase_e          phase;
    logic [CntW-1:0] count;
    logic [CntW-1:0] total;
    logic [2:0]      rank;
    logic            err;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase: PH_START,
    count: '0,
    total: '0,
    rank:  RankNone,
    err:   1'b0
  };

  // Length of a unit in seconds.
  function automatic logic [ScaleW-1:0] unit_scale(input logic [2:0] rank);
    logic [ScaleW-1:0] s;
    case (rank)
      RankDay:  s = 17'd86400;
      RankHour: s = 17'd3600;
      RankMin:  s = 17'd60;
      default:  s = 17'd1;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/dsts_step.sv @@
// One-character state update of the duration parser.
module dsts_step (
  input  dsts_pkg::parse_state_t cur_i,
  input  logic [7:0]             char_i,
  input  logic                   none_i,
  output dsts_pkg::parse_state_t nxt_o
);
  import dsts_pkg::*;

  logic                 digit;
  logic [3:0]           dval;
  logic [CntW+3:0]      mul10;
  logic [CntW+3:0]      next_cnt;
  logic                 is_unit;
  logic [2:0]           urank;
  phase_e               uphase;
  logic [ScaleW-1:0]    scale;
  logic [CntW+ScaleW-1:0] prod;
  logic [CntW+ScaleW:0]   sum;

  // Digit decode and decimal accumulation (count * 10 + digit).
  assign digit    = (char_i >= ChZero) && (char_i <= ChNine);
  assign dval     = char_i[3:0];
  assign mul10    = {1'b0, cur_i.count, 3'b000} + {3'b000, cur_i.count, 1'b0}
                  + {{CntW{1'b0}}, dval};
  assign next_cnt = (cur_i.phase == PH_NUMBER) ? mul10 : {{CntW{1'b0}}, dval};

  // Unit decode.
  always_comb begin
    is_unit = 1'b1;
    urank   = RankSec;
    uphase  = PH_AFTER_S;
    case (char_i)
      ChD: begin
        urank  = RankDay;
        uphase = PH_EXPECT;
      end
      ChH: begin
        urank  = RankHour;
        uphase = PH_EXPECT;
      end
      ChM: begin
        urank  = RankMin;
        uphase = PH_AFTER_M;
      end
      ChS: begin
        urank  = RankSec;
        uphase = PH_AFTER_S;
      end
      default: is_unit = 1'b0;
    endcase
  end

  // Scaled count added to the running total.
  assign scale = unit_scale(urank);
  assign prod  = {{ScaleW{1'b0}}, cur_i.count} * {{CntW{1'b0}}, scale};
  assign sum   = {1'b0, prod} + {{(ScaleW+1){1'b0}}, cur_i.total};

  // Next parser state.
  always_comb begin
    nxt_o = cur_i;
    if (!none_i && !cur_i.err) begin
      if (digit && (cur_i.phase != PH_AFTER_MI) && (cur_i.phase != PH_AFTER_SE)) begin
        if (next_cnt[CntW+3:CntW] != 4'd0) begin
          nxt_o.err = 1'b1;
        end else begin
          nxt_o.count = next_cnt[CntW-1:0];
          nxt_o.phase = PH_NUMBER;
        end
      end else if (cur_i.phase == PH_NUMBER) begin
        if (is_unit) begin
          nxt_o.phase = uphase;
          if (urank >= cur_i.rank) begin
            nxt_o.err = 1'b1;
          end else begin
            nxt_o.rank = urank;
            if (sum[CntW+ScaleW:CntW] != '0) begin
              nxt_o.err = 1'b1;
            end else begin
              nxt_o.total = sum[CntW-1:0];
            end
          end
        end else begin
          nxt_o.err = 1'b1;
        end
      end else if ((cur_i.phase == PH_AFTER_M) && (char_i == ChI)) begin
        nxt_o.phase = PH_AFTER_MI;
      end else if ((cur_i.phase == PH_AFTER_MI) && (char_i == ChN)) begin
        nxt_o.phase = PH_EXPECT;
      end else if ((cur_i.phase == PH_AFTER_S) && (char_i == ChE)) begin
        nxt_o.phase = PH_AFTER_SE;
      end else if ((cur_i.phase == PH_AFTER_SE) && (char_i == ChC)) begin
        nxt_o.phase = PH_EXPECT;
      end else begin
        nxt_o.err = 1'b1;
      end
    end
  end

endmodule

@@ hdl/duration_string_to_seconds_core.sv @@
// Top level of the duration parser: input register, step logic and result register.
// The last character passes through the input register and the step logic into the result
// register, where the result is offered until m_axis_tready takes it.
// Throughput: one character per cycle through the combinational step logic (a constant-scale
// multiply, add and range check); a last character waits only while a result is stalled.
// Reset (rst_ni low, asynchronous) empties both registers and starts a new string.
module duration_string_to_seconds_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_char
  input  logic        s_axis_tuser,   // no_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] total_seconds, [31] zero
  output logic        m_axis_tuser    // parse_ok
);
  import dsts_pkg::*;
  `include "duration_string_to_seconds_core_macros.svh"

  logic            in_valid_q;
  logic [7:0]      in_char_q;
  logic            in_last_q;
  logic            in_none_q;
  logic            in_fire;
  logic            step_fire;
  logic            last_step;
  parse_state_t    state_q;
  parse_state_t    state_d;
  parse_state_t    stepped;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            out_ok_q;
  logic [CntW-1:0] out_total_q;
  logic            ok;

  // Input register holds one character; the step runs on it when the result
  // side can take whatever it produces.
  assign step_fire     = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign last_step     = step_fire && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
      in_none_q <= s_axis_tuser;
    end
  end

  // Character step logic.
  dsts_step u_step (
    .cur_i  (state_q),
    .char_i (in_char_q),
    .none_i (in_none_q),
    .nxt_o  (stepped)
  );

  assign ok = !stepped.err && ((stepped.phase == PH_EXPECT) ||
              (stepped.phase == PH_AFTER_M) || (stepped.phase == PH_AFTER_S));

  // Parser state: advance per character, clear after the last one.
  always_comb begin
    state_d = state_q;
    if (step_fire) begin
      state_d = in_last_q ? StateReset : stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && in_last_q) begin
      out_ok_q    <= ok;
      out_total_q <= ok ? stepped.total : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {1'b0, out_total_q};

  // A failed parse never reports a nonzero total.
  `DSTS_ASSERT_SAME(a_fail_zero, out_valid_q && !out_ok_q, out_total_q == '0, "failed total")
  // The parser is back at its start state after a last character.
  `DSTS_ASSERT_NEXT(a_clear_after_last, last_step, state_q == StateReset, "state not cleared")
  // An error stays until the string ends.
  `DSTS_ASSERT_NEXT(a_err_sticky, state_q.err && !last_step, state_q.err, "error flag dropped")
  // Unit ranks never rise within a string.
  `DSTS_ASSERT_NEXT(a_rank_down, !last_step, state_q.rank <= $past(state_q.rank), "unit rank rose")
  // A waiting result is never overwritten by a new one.
  `DSTS_ASSERT_SAME(a_no_overwrite, out_valid_q && !m_axis_tready, !last_step, "result overwritten")

endmodule

@@ bench/duration_checker.sv @@
// Checker for the duration parser: predicts each result from accepted characters and compares.
`timescale 1ns / 100ps

module duration_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,   // [7:0] char_byte
  input  logic        in_last_i,   // last_char
  input  logic        in_user_i,   // no_char
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,  // [30:0] total_seconds, [31] zero
  input  logic        out_user_i,  // parse_ok
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import dsts_pkg::*;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned SecsPerSec  = 1;

  typedef struct packed {
    logic            ok;
    logic [CntW-1:0] secs;
  } duration_t;

  // Parser state as the predictor sees it.
  phase_e          cur_phase;
  logic [CntW-1:0] cur_count;
  logic [CntW-1:0] cur_total;
  logic [2:0]      cur_rank;
  logic            cur_err;

  duration_t   expected_durations[$];
  int unsigned failures;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    failures++;
  endtask

  task automatic clear_parse();
    cur_phase = PH_START;
    cur_count = '0;
    cur_total = '0;
    cur_rank  = RankNone;
    cur_err   = 1'b0;
  endtask

  // Adds the current count in seconds; units must come in strictly falling rank.
  task automatic apply_unit(input logic [2:0] rank, input int unsigned secs);
    logic [63:0] sum;
    if (rank >= cur_rank) begin
      cur_err = 1'b1;
      return;
    end
    cur_rank = rank;
    sum = 64'(cur_total) + 64'(cur_count) * 64'(secs);
    if (sum > 64'(Max31)) cur_err = 1'b1;
    else cur_total = sum[CntW-1:0];
  endtask

  // Advances the predicted parser by one character.
  task automatic parse_char(input logic [7:0] ch);
    logic [63:0] next_count;
    logic        is_digit;
    is_digit = (ch >= ChZero) && (ch <= ChNine);
    if (cur_err) return;
    if (is_digit && cur_phase != PH_AFTER_MI && cur_phase != PH_AFTER_SE) begin
      next_count = 64'(ch - ChZero);
      if (cur_phase == PH_NUMBER) next_count = 64'(cur_count) * 10 + next_count;
      if (next_count > 64'(Max31)) begin
        cur_err = 1'b1;
      end else begin
        cur_count = next_count[CntW-1:0];
        cur_phase = PH_NUMBER;
      end
    end else if (cur_phase == PH_NUMBER) begin
      case (ch)
        ChD: begin
          apply_unit(RankDay, SecsPerDay);
          cur_phase = PH_EXPECT;
        end
        ChH: begin
          apply_unit(RankHour, SecsPerHour);
          cur_phase = PH_EXPECT;
        end
        ChM: begin
          apply_unit(RankMin, SecsPerMin);
          cur_phase = PH_AFTER_M;
        end
        ChS: begin
          apply_unit(RankSec, SecsPerSec);
          cur_phase = PH_AFTER_S;
        end
        default: cur_err = 1'b1;
      endcase
    end else if (cur_phase == PH_AFTER_M && ch == ChI) begin
      cur_phase = PH_AFTER_MI;
    end else if (cur_phase == PH_AFTER_MI && ch == ChN) begin
      cur_phase = PH_EXPECT;
    end else if (cur_phase == PH_AFTER_S && ch == ChE) begin
      cur_phase = PH_AFTER_SE;
    end else if (cur_phase == PH_AFTER_SE && ch == ChC) begin
      cur_phase = PH_EXPECT;
    end else begin
      cur_err = 1'b1;
    end
  endtask

  // Watch both channels; results are checked before new characters are taken.
  always @(posedge clk_i or negedge rst_ni) begin
    duration_t want;
    duration_t done;
    if (!rst_ni) begin
      clear_parse();
      expected_durations.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_durations.size() == 0) begin
          report_mismatch("unexpected result, total_seconds", out_data_i, 0);
        end else begin
          want = expected_durations.pop_front();
          if (out_user_i !== want.ok)
            report_mismatch("parse_ok", out_user_i, want.ok);
          if (out_data_i[CntW-1:0] !== want.secs)
            report_mismatch("total_seconds", out_data_i[CntW-1:0], want.secs);
          if (out_data_i[31] !== 1'b0)
            report_mismatch("tdata pad bit", out_data_i[31], 0);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (!in_user_i) parse_char(in_data_i);
        if (in_last_i) begin
          done.ok = !cur_err && (cur_phase == PH_EXPECT || cur_phase == PH_AFTER_M ||
                                 cur_phase == PH_AFTER_S);
          done.secs = done.ok ? cur_total : '0;
          expected_durations.push_back(done);
          clear_parse();
        end
      end
      fail_count_o <= failures;
      pending_o    <= expected_durations.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Top of the duration parser bench: clock, reset, character stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb;
  import dsts_pkg::*;

  localparam int unsigned ItemTarget    = 1150;
  localparam int unsigned TailItems     = 150;
  localparam int unsigned LongHold      = 48;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam string       NoiseChars    = "0123456789dhmsinecx";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned item_count = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;
  logic [7:0]  text_q[$];

  always #5 clk_i = ~clk_i;

  duration_string_to_seconds_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  duration_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on each request.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else if (hold == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 6);
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the edge of its transfer.
  task automatic send_item(input logic [7:0] ch, input logic last, input logic none);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    s_axis_tuser  <= none;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Sends text_q as one string; a character-free last item may close it.
  task automatic send_text(input bit marker_end);
    int unsigned n;
    n = text_q.size();
    foreach (text_q[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_item(text_q[i], (i == n - 1) && !marker_end, 1'b0);
      item_count++;
    end
    if (marker_end || n == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      item_count++;
    end
  endtask

  task automatic load_text(input string s);
    text_q = {};
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic append_number(input longint unsigned value);
    logic [7:0]       digs[$];
    longint unsigned  r;
    r = value;
    do begin
      digs.push_front(ChZero + 8'(r % 10));
      r = r / 10;
    end while (r != 0);
    if ($urandom_range(0, 9) == 0) digs.push_front(ChZero);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  task automatic append_unit(input logic [2:0] rank, input bit long_form);
    case (rank)
      RankDay:  text_q.push_back(ChD);
      RankHour: text_q.push_back(ChH);
      RankMin: begin
        text_q.push_back(ChM);
        if (long_form) begin
          text_q.push_back(ChI);
          text_q.push_back(ChN);
        end
      end
      default: begin
        text_q.push_back(ChS);
        if (long_form) begin
          text_q.push_back(ChE);
          text_q.push_back(ChC);
        end
      end
    endcase
  endtask

  // Counts are mostly small; some sit at or past the 31-bit limit.
  function automatic longint unsigned pick_count();
    case ($urandom_range(0, 9))
      0:       return longint'($urandom);
      1:       return longint'(Max31) + $urandom_range(0, 1);
      2, 3:    return $urandom_range(0, 99999);
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  // Builds a well-formed duration, sometimes with one flaw worked in.
  task automatic build_duration();
    int unsigned mask;
    int unsigned idx;
    text_q = {};
    mask = $urandom_range(1, 15);
    for (int r = int'(RankDay); r >= int'(RankSec); r--) begin
      if (mask[r]) begin
        append_number(pick_count());
        append_unit(3'(r), 1'($urandom_range(0, 1)));
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        append_number(pick_count());
        append_unit(3'($urandom_range(RankSec, RankDay)), 1'($urandom_range(0, 1)));
      end
      1: append_number(pick_count());
      2: if (text_q.size() > 1) repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
      3: begin
        idx = $urandom_range(0, text_q.size() - 1);
        text_q[idx] = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
  endtask

  task automatic build_noise();
    text_q = {};
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) == 0)
        text_q.push_back(8'($urandom_range(0, 255)));
      else
        text_q.push_back(NoiseChars[$urandom_range(0, NoiseChars.len() - 1)]);
    end
  endtask

  // Holds the sender until every expected result has come back.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Main stimulus and verdict.
  initial begin
    int unsigned str_idx;
    int unsigned kind;
    str_idx = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: empty, every unit (min and sec spelled out), a cut-off "min",
    // byte extremes and a misordered pair.
    text_q = {};
    send_text(1'b1);
    load_text("1d2h3min4sec");
    send_text(1'b0);
    load_text("9mi");
    send_text(1'b0);
    text_q = {8'h00, 8'hFF};
    send_text(1'b0);
    load_text("2s1m");
    send_text(1'b1);
    wait_results();

    // Random strings, mostly well-formed, some noise and empty strings.
    while (item_count < ItemTarget) begin
      str_idx++;
      gaps_on = (item_count < ItemTarget - TailItems) && ((str_idx / 40) % 4 != 3);
      if (str_idx == 30 || str_idx == 120) long_hold_req = 1'b1;
      kind = $urandom_range(0, 19);
      if (kind == 0) text_q = {};
      else if (kind <= 3) build_noise();
      else build_duration();
      send_text($urandom_range(0, 7) == 0);
      if (str_idx % 50 == 0) wait_results();
    end

    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
